@@ rtl/cfr_pkg.sv @@
package cfr_pkg;

  // byte that closes a frame
  localparam logic [7:0] FRAME_END = 8'h0A;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LEN_RD  = 9'b000000010,
    S_LEN_WT  = 9'b000000100,
    S_CHK_WT  = 9'b000001000,
    S_XOR_RD  = 9'b000010000,
    S_XOR_WT  = 9'b000100000,
    S_CMP     = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_EMIT_WT = 9'b100000000
  } state_t;

endpackage

@@ rtl/cfr_ram.sv @@
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/checked_frame_receiver.sv @@
// checked_frame_receiver: receives one byte per input word and stores it in a ring of the
// last RING_DEPTH bytes. A byte of 0x0A closes a frame laid out as payload, length, checksum,
// terminator. The length must be at most MAX_PAYLOAD and the checksum must equal the XOR of
// the length and the payload bytes; a good frame is then sent out one payload byte per output
// word, oldest first, with out_is_last on the final word, and an empty good frame gives a
// single word with out_is_empty set. A terminator holds in_stall high while a small sequencer
// walks the ring through its single read port, first to check the frame and then to emit its
// payload bytes, pausing while the output register is stalled. Results sit in an output
// register, so the next input word is taken while the last result is still waiting. The ring
// has no reset; slots that were never written since reset read as zero, tracked by the write
// pointer and a wrap flag.
module checked_frame_receiver #(
  parameter int RING_DEPTH  = 128,
  parameter int MAX_PAYLOAD = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  // input word channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result word channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_frame_len,
  output logic       out_is_last,
  output logic       out_is_empty
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  // ring pointer steps with wrap
  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(RING_DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  cfr_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]    wp_r, wp_nxt;        // next slot to write
  logic             full_r, full_nxt;    // every slot written at least once
  logic [AW-1:0]    ptr_r, ptr_nxt;      // walking read pointer
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;      // bytes still to fold or emit
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             rd_ok_r;             // slot just read had been written

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [5:0]       out_len_r, out_len_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_empty_r, out_empty_nxt;

  logic             in_acc;
  logic             out_free;            // output register can take a word this cycle
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic [7:0]       rd_byte;             // ring byte, zero for never-written slots

  assign in_acc   = in_valid && (state_r == cfr_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_byte  = rd_ok_r ? rd_data : 8'h00;

  // single ring read port, shared by the read steps of the check and the emit
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r;
    unique case (state_r)
      cfr_pkg::S_LEN_RD,
      cfr_pkg::S_XOR_RD,
      cfr_pkg::S_EMIT_RD: rd_en = 1'b1;
      cfr_pkg::S_LEN_WT: begin
        rd_en   = 1'b1;
        rd_addr = ptr_inc(ptr_r);   // checksum sits just after the length
      end
      default: rd_en = 1'b0;
    endcase
  end

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    ptr_nxt       = ptr_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;

    unique case (state_r)
      cfr_pkg::S_IDLE: begin
        if (in_acc) begin
          wp_nxt = ptr_inc(wp_r);
          if (wp_r == AW'(RING_DEPTH - 1)) begin
            full_nxt = 1'b1;
          end
          if (in_rx_byte == cfr_pkg::FRAME_END) begin
            // length byte two slots before the terminator
            ptr_nxt   = ptr_dec(ptr_dec(wp_r));
            state_nxt = cfr_pkg::S_LEN_RD;
          end
        end
      end
      cfr_pkg::S_LEN_RD: state_nxt = cfr_pkg::S_LEN_WT;
      cfr_pkg::S_LEN_WT: begin
        if (rd_byte > 8'(MAX_PAYLOAD)) begin
          state_nxt = cfr_pkg::S_IDLE;
        end else begin
          len_nxt   = LEN_W'(rd_byte);
          cnt_nxt   = LEN_W'(rd_byte);
          sum_nxt   = rd_byte;
          state_nxt = cfr_pkg::S_CHK_WT;
        end
      end
      cfr_pkg::S_CHK_WT: begin
        chk_nxt = rd_byte;
        if (len_r == '0) begin
          state_nxt = cfr_pkg::S_CMP;
        end else begin
          ptr_nxt   = ptr_dec(ptr_r);
          state_nxt = cfr_pkg::S_XOR_RD;
        end
      end
      cfr_pkg::S_XOR_RD: state_nxt = cfr_pkg::S_XOR_WT;
      cfr_pkg::S_XOR_WT: begin
        // walking back; pointer stops on the oldest payload byte
        sum_nxt = sum_r ^ rd_byte;
        cnt_nxt = cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = cfr_pkg::S_CMP;
        end else begin
          ptr_nxt   = ptr_dec(ptr_r);
          state_nxt = cfr_pkg::S_XOR_RD;
        end
      end
      cfr_pkg::S_CMP: begin
        if (sum_r != chk_r) begin
          state_nxt = cfr_pkg::S_IDLE;
        end else if (len_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = 8'h00;
            out_len_nxt   = 6'h00;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            state_nxt     = cfr_pkg::S_IDLE;
          end
        end else begin
          cnt_nxt   = len_r;
          state_nxt = cfr_pkg::S_EMIT_RD;
        end
      end
      cfr_pkg::S_EMIT_RD: state_nxt = cfr_pkg::S_EMIT_WT;
      cfr_pkg::S_EMIT_WT: begin
        // read data holds until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_byte;
          out_len_nxt   = 6'(len_r);
          out_last_nxt  = (cnt_r == LEN_W'(1));
          out_empty_nxt = 1'b0;
          cnt_nxt       = cnt_r - LEN_W'(1);
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = cfr_pkg::S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc(ptr_r);
            state_nxt = cfr_pkg::S_EMIT_RD;
          end
        end
      end
      default: state_nxt = cfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfr_pkg::S_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    len_r       <= len_nxt;
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    chk_r       <= chk_nxt;
    out_byte_r  <= out_byte_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    if (rd_en) begin
      // slot counts as written once the pointer has passed it or the ring has wrapped
      rd_ok_r <= full_r || (rd_addr < wp_r);
    end
  end

  assign in_stall         = (state_r != cfr_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_len    = out_len_r;
  assign out_is_last      = out_last_r;
  assign out_is_empty     = out_empty_r;

endmodule

@@ verif/cfr_tb_pkg.sv @@
package cfr_tb_pkg;

  localparam int RING_SLOTS  = 128;
  localparam int PAYLOAD_MAX = 63;
  localparam int PTR_W       = $clog2(RING_SLOTS);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] frame_len;
    logic       is_last;
    logic       is_empty;
  } frame_word_t;

  // keeps a shadow of the byte ring and queues the words each terminator releases
  class frame_scoreboard;

    logic [7:0]       ring_mem [RING_SLOTS];
    logic [PTR_W-1:0] wr_ptr;
    frame_word_t      expected_words [$];
    int               errors;
    int               words_checked;
    int               frames_ok;
    int               longest_frame;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      wr_ptr        = '0;
      errors        = 0;
      words_checked = 0;
      frames_ok     = 0;
      longest_frame = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // store one received byte and, on a terminator, deframe what ends there
    function void note_byte(logic [7:0] rx);
      logic [PTR_W-1:0] term;
      logic [PTR_W-1:0] idx;
      logic [7:0]       len;
      logic [7:0]       sum;
      frame_word_t      w;
      term           = wr_ptr;
      ring_mem[term] = rx;
      wr_ptr         = wr_ptr + 1'b1;
      if (rx != cfr_pkg::FRAME_END) return;
      len = ring_mem[PTR_W'(term - 2)];
      if (len > PAYLOAD_MAX) return;
      sum = len;
      idx = PTR_W'(term - 2 - len);
      for (int k = 0; k < len; k++) begin
        sum = sum ^ ring_mem[idx];
        idx = idx + 1'b1;
      end
      if (sum != ring_mem[PTR_W'(term - 1)]) return;
      frames_ok++;
      if (len > longest_frame) longest_frame = len;
      if (len == 0) begin
        w.payload_byte = 8'h00;
        w.frame_len    = 6'd0;
        w.is_last      = 1'b1;
        w.is_empty     = 1'b1;
        expected_words.push_back(w);
        return;
      end
      idx = PTR_W'(term - 2 - len);
      for (int k = 0; k < len; k++) begin
        w.payload_byte = ring_mem[idx];
        w.frame_len    = len[5:0];
        w.is_last      = (k == len - 1);
        w.is_empty     = 1'b0;
        expected_words.push_back(w);
        idx = idx + 1'b1;
      end
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: byte %02h len %0d last %0d empty %0d",
                   got.payload_byte, got.frame_len, got.is_last, got.is_empty);
        return;
      end
      want = expected_words.pop_front();
      if (got.payload_byte != want.payload_byte || got.frame_len != want.frame_len ||
          got.is_last != want.is_last || got.is_empty != want.is_empty) begin
        errors++;
        // fields shown as byte/len/last/empty
        if (errors <= 10)
          $display("word %0d mismatch: exp %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                   words_checked, want.payload_byte, want.frame_len, want.is_last,
                   want.is_empty, got.payload_byte, got.frame_len, got.is_last,
                   got.is_empty);
      end
    endfunction

  endclass

endpackage

@@ verif/tb_checked_frame_receiver.sv @@
module tb_checked_frame_receiver;

  timeunit 1ns;
  timeprecision 1ps;

  // generous: covers max frames with every result word waiting out long stalls
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic [5:0] out_frame_len;
  logic       out_is_last;
  logic       out_is_empty;

  cfr_tb_pkg::frame_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  checked_frame_receiver #(
    .RING_DEPTH (cfr_tb_pkg::RING_SLOTS),
    .MAX_PAYLOAD(cfr_tb_pkg::PAYLOAD_MAX)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_frame_len   (out_frame_len),
    .out_is_last     (out_is_last),
    .out_is_empty    (out_is_empty)
  );

  always #2 clk = ~clk;

  // watchdog, counts every cycle from time zero
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               sb.pending());
      $display("tb_checked_frame_receiver NOT OK");
      $finish;
    end
  end

  // input side monitor: every accepted byte goes through the shadow ring
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_rx_byte);
  end

  // result side: check the accepted word, then pick next cycle's stall
  always @(posedge clk) begin
    cfr_tb_pkg::frame_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.payload_byte = out_payload_byte;
      got.frame_len    = out_frame_len;
      got.is_last      = out_is_last;
      got.is_empty     = out_is_empty;
      sb.check_word(got);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one input word; random gaps first, then hold until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // payload, length byte, checksum (optionally spoiled), terminator
  task automatic send_frame(input int n_payload, input logic [7:0] len_byte,
                            input logic bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len_byte;
    repeat (n_payload) begin
      b   = 8'($urandom_range(255));
      sum = sum ^ b;
      send_byte(b);
    end
    send_byte(len_byte);
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    send_byte(cfr_pkg::FRAME_END);
  endtask

  // mostly good short frames with random content, some noise and broken frames
  task automatic random_traffic(input int byte_target);
    int pick;
    int n;
    while (bytes_sent < byte_target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // stray byte, often a terminator on its own
        if ($urandom_range(3) == 0) send_byte(cfr_pkg::FRAME_END);
        else send_byte(8'($urandom_range(255)));
      end else if (pick < 17) begin
        n = $urandom_range(8);
        send_frame(n, 8'(n), 1'b1);
      end else if (pick < 22) begin
        // length field above the limit
        send_frame($urandom_range(6),
                   8'($urandom_range(cfr_tb_pkg::PAYLOAD_MAX + 1, 255)), 1'b0);
      end else if (pick < 25) begin
        n = $urandom_range(40, cfr_tb_pkg::PAYLOAD_MAX);
        send_frame(n, 8'(n), 1'b0);
      end else begin
        n = $urandom_range(8);
        send_frame(n, 8'(n), 1'b0);
      end
    end
  endtask

  // sender holds off until every expected word has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender gaps 37%, receiver stalls 49%
    send_idle_pct = 37;
    recv_idle_pct = 49;

    // terminator straight after reset, framed by never-written zero slots
    send_byte(cfr_pkg::FRAME_END);
    // empty frame
    send_frame(0, 8'h00, 1'b0);
    // single all-ones payload byte
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(cfr_pkg::FRAME_END);
    // two bytes, oldest first
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h02);
    send_byte(8'h24);
    send_byte(cfr_pkg::FRAME_END);
    // length one past the limit
    send_byte(8'h40);
    send_byte(8'h40);
    send_byte(cfr_pkg::FRAME_END);
    // checksum mismatch
    send_byte(8'h05);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(cfr_pkg::FRAME_END);
    // terminator value carried as payload
    send_byte(cfr_pkg::FRAME_END);
    send_byte(8'h01);
    send_byte(8'h0B);
    send_byte(cfr_pkg::FRAME_END);

    random_traffic(85);
    wait_for_results();

    // phase 2: roles swapped
    send_idle_pct = 49;
    recv_idle_pct = 37;
    random_traffic(150);
    wait_for_results();

    // phase 3: no gaps either side, one frame of maximum length, then random traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(cfr_tb_pkg::PAYLOAD_MAX, 8'(cfr_tb_pkg::PAYLOAD_MAX), 1'b0);
    random_traffic(220);
    wait_for_results();

    // let any frame that yields nothing finish its ring walk
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d input words; %0d frames passed the check, %0d result words seen",
             bytes_sent, sb.frames_ok, sb.words_checked);
    $display("longest good frame %0d bytes, %0d mismatches, %0d words never seen",
             sb.longest_frame, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_checked_frame_receiver OK");
    end else begin
      $display("tb_checked_frame_receiver NOT OK");
    end
    $finish;
  end

endmodule

@@ checked_frame_receiver.f @@
rtl/cfr_pkg.sv
rtl/cfr_ram.sv
rtl/checked_frame_receiver.sv
verif/cfr_tb_pkg.sv
verif/tb_checked_frame_receiver.sv
